>>> design/ldpm_pkg.sv
// ----------------------------------------------------------------------------
// ldpm_pkg
// Shared types and constants of the lens distortion point map: beat payloads,
// register map codes, reset values and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package ldpm_pkg;

  localparam int MAX_DIM_DEF   = 4096;
  localparam int FRAC_BITS_DEF = 16;
  localparam int COEF_FRAC     = 16;
  localparam int COEF_W        = 18;
  localparam int CFG_AW        = 5;
  localparam int CFG_DW        = 32;

  typedef enum logic [2:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_RADIAL_K1    = 3'd2,
    REG_RADIAL_K2    = 3'd3,
    REG_RADIAL_K3    = 3'd4,
    REG_TANG_P1      = 3'd5,
    REG_TANG_P2      = 3'd6
  } cfg_reg_t;

  localparam logic [12:0] FRAME_WIDTH_RST  = 13'd1920;
  localparam logic [12:0] FRAME_HEIGHT_RST = 13'd1080;
  localparam logic [17:0] RADIAL_K1_RST    = 18'h33333; // -52429, about -0.8

  typedef struct packed {
    logic [11:0] x_in;
    logic [11:0] y_in;
    logic        is_border;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] x_out;
    logic signed [15:0] y_out;
    logic               saturated;
  } out_beat_t;

endpackage

`default_nettype wire

>>> design/lens_distortion_point_map_top.sv
// ----------------------------------------------------------------------------
// lens_distortion_point_map_top
// Brown-Conrady radial and tangential distortion of one mesh vertex per beat,
// in a fully pipelined fixed-point datapath with an APB register port.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_data carry one vertex beat (x_in, y_in, is_border); it is
//   taken when in_valid is high and in_stall is low. out_valid/out_data carry
//   the distorted vertex (x_out, y_out, saturated); the receiver holds it
//   with out_stall.
//   The pipe is one capture stage, FRAC_BITS + 1 restoring divider stages
//   for the normalisation, then eight arithmetic stages and the output
//   register. One beat is accepted every cycle while the output is not
//   stalled.
//   A stall on the output freezes the whole pipeline; in_stall rises in the
//   same cycle, so nothing is dropped or repeated.
//   Registers (frame size, k1..k3, p1, p2) are written over APB at byte
//   address 4*index and must only be changed while the pipeline is empty.
//   Reset (rst_n low, synchronous) empties the pipeline and loads the
//   register reset values; border vertices pass through unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module lens_distortion_point_map_top
  import ldpm_pkg::*;
#(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_beat_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_beat_t              out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready
);

  localparam int F    = FRAC_BITS;
  localparam int DW   = $clog2(MAX_DIM + 1);
  localparam int DDW  = ((DW > 13) ? DW : 13) + 1;
  localparam int RW   = DDW;
  localparam int XW   = F + 2;
  localparam int PW   = F + 4;
  localparam int R2W  = F + 5;
  localparam int R4W  = F + 8;
  localparam int R6W  = F + 11;
  localparam int TAW  = F + 6;
  localparam int TW   = F + 8;
  localparam int MW   = F + 13;
  localparam int DXW  = F + 15;
  localparam int SW   = DW + DXW + 2;
  localparam int VW   = SW - F;
  localparam int CW   = COEF_W;
  localparam int LIM  = (1 << (F + 1)) - 1;

  // stage indices
  localparam int IN_S = F + 2;
  localparam int IP7  = F + 9;
  localparam int IO   = F + 10;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  logic [12:0] frame_width_r, frame_height_r;
  logic [17:0] k1_r, k2_r, k3_r, p1_r, p2_r;
  logic [2:0]  reg_idx;

  assign reg_idx = paddr[CFG_AW-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
      k1_r           <= RADIAL_K1_RST;
      k2_r           <= '0;
      k3_r           <= '0;
      p1_r           <= '0;
      p2_r           <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_FRAME_WIDTH:  frame_width_r  <= pwdata[12:0];
        REG_FRAME_HEIGHT: frame_height_r <= pwdata[12:0];
        REG_RADIAL_K1:    k1_r           <= pwdata[17:0];
        REG_RADIAL_K2:    k2_r           <= pwdata[17:0];
        REG_RADIAL_K3:    k3_r           <= pwdata[17:0];
        REG_TANG_P1:      p1_r           <= pwdata[17:0];
        REG_TANG_P2:      p2_r           <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRAME_WIDTH:  prdata = {19'd0, frame_width_r};
      REG_FRAME_HEIGHT: prdata = {19'd0, frame_height_r};
      REG_RADIAL_K1:    prdata = {14'd0, k1_r};
      REG_RADIAL_K2:    prdata = {14'd0, k2_r};
      REG_RADIAL_K3:    prdata = {14'd0, k3_r};
      REG_TANG_P1:      prdata = {14'd0, p1_r};
      REG_TANG_P2:      prdata = {14'd0, p2_r};
      default:          prdata = '0;
    endcase
  end

  function automatic logic [DW-1:0] clamp_dim(input logic [12:0] d);
    int v;
    v = int'(d);
    if (v < 2) v = 2;
    else if (v > MAX_DIM) v = MAX_DIM;
    return DW'(v);
  endfunction

  logic [DW-1:0] dim_l [0:1];
  logic [11:0]   pix_l [0:1];

  assign dim_l[0] = clamp_dim(frame_width_r);
  assign dim_l[1] = clamp_dim(frame_height_r);
  assign pix_l[0] = in_data.x_in;
  assign pix_l[1] = in_data.y_in;

  // --------------------------------------------------------------------------
  // Pipeline control: the whole pipe advances unless the output beat is held
  // --------------------------------------------------------------------------
  logic     adv;
  logic     vld_r  [0:IO];
  in_beat_t meta_r [0:IP7];

  assign adv      = !(vld_r[IO] && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= IO; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i <= IO; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      meta_r[0] <= in_data;
      for (int i = 1; i <= IP7; i++) meta_r[i] <= meta_r[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // Capture: offset from the centre, magnitude, far-off flag
  // --------------------------------------------------------------------------
  logic [RW-1:0]         a_abs_r [0:1];
  logic                  a_neg_r [0:1];
  logic                  a_ovf_r [0:1];
  logic signed [DDW-1:0] a_d     [0:1];
  logic [RW-1:0]         a_abs   [0:1];
  logic                  a_ovf   [0:1];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      a_d[l]   = DDW'($signed({1'b0, pix_l[l]})) -
                 DDW'($signed({1'b0, dim_l[l] >> 1}));
      a_abs[l] = a_d[l][DDW-1] ? RW'(-a_d[l]) : RW'(a_d[l]);
      // a quotient of two or more frame sizes clamps to the limit
      a_ovf[l] = (RW + 1)'(a_abs[l]) >= (RW + 1)'({dim_l[l], 1'b0});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 2; l++) begin
        a_abs_r[l] <= a_abs[l];
        a_neg_r[l] <= a_d[l][DDW-1];
        a_ovf_r[l] <= a_ovf[l];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Restoring divider: one quotient bit per stage, F+1 stages
  // --------------------------------------------------------------------------
  logic [RW-1:0] drem_r [0:F][0:1];
  logic [F:0]    dq_r   [0:F][0:1];
  logic          dneg_r [0:F][0:1];
  logic          dovf_r [0:F][0:1];
  logic [RW-1:0] dsh    [0:F][0:1];
  logic [F:0]    dqi    [0:F][0:1];
  logic          dbit   [0:F][0:1];

  always_comb begin
    for (int j = 0; j <= F; j++) begin
      for (int l = 0; l < 2; l++) begin
        if (j == 0) begin
          dsh[j][l] = a_abs_r[l];
          dqi[j][l] = '0;
        end else begin
          dsh[j][l] = drem_r[(j == 0) ? 0 : j - 1][l] << 1;
          dqi[j][l] = dq_r[(j == 0) ? 0 : j - 1][l];
        end
        dbit[j][l] = dsh[j][l] >= RW'(dim_l[l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j <= F; j++) begin
        for (int l = 0; l < 2; l++) begin
          drem_r[j][l] <= dbit[j][l] ? dsh[j][l] - RW'(dim_l[l]) : dsh[j][l];
          dq_r[j][l]   <= {dqi[j][l][F-1:0], dbit[j][l]};
          if (j == 0) begin
            dneg_r[j][l] <= a_neg_r[l];
            dovf_r[j][l] <= a_ovf_r[l];
          end else begin
            dneg_r[j][l] <= dneg_r[(j == 0) ? 0 : j - 1][l];
            dovf_r[j][l] <= dovf_r[(j == 0) ? 0 : j - 1][l];
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Normalised coordinates, sign applied, clamped to the limit
  // --------------------------------------------------------------------------
  logic signed [XW-1:0] xn_r, yn_r, xn_nxt, yn_nxt;
  logic [F:0]           vx_q, vy_q;

  always_comb begin
    vx_q   = dovf_r[F][0] ? {(F+1){1'b1}} : dq_r[F][0];
    vy_q   = dovf_r[F][1] ? {(F+1){1'b1}} : dq_r[F][1];
    xn_nxt = dneg_r[F][0] ? -$signed({1'b0, vx_q}) : $signed({1'b0, vx_q});
    yn_nxt = dneg_r[F][1] ? -$signed({1'b0, vy_q}) : $signed({1'b0, vy_q});
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xn_r <= xn_nxt;
      yn_r <= yn_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // P1: squares and cross product
  // --------------------------------------------------------------------------
  logic signed [2*XW-1:0] pxx, pyy, pxy;
  logic signed [PW-1:0]   xx_p1_r, yy_p1_r, xy_p1_r;
  logic signed [XW-1:0]   x_p1_r, y_p1_r;

  assign pxx = (2*XW)'(xn_r) * (2*XW)'(xn_r);
  assign pyy = (2*XW)'(yn_r) * (2*XW)'(yn_r);
  assign pxy = (2*XW)'(xn_r) * (2*XW)'(yn_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      xx_p1_r <= PW'(pxx >>> F);
      yy_p1_r <= PW'(pyy >>> F);
      xy_p1_r <= PW'(pxy >>> F);
      x_p1_r  <= xn_r;
      y_p1_r  <= yn_r;
    end
  end

  // --------------------------------------------------------------------------
  // P2: r^2
  // --------------------------------------------------------------------------
  logic signed [R2W-1:0] r2_p2_r;
  logic signed [PW-1:0]  xx_p2_r, yy_p2_r, xy_p2_r;
  logic signed [XW-1:0]  x_p2_r, y_p2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      r2_p2_r <= R2W'(xx_p1_r) + R2W'(yy_p1_r);
      xx_p2_r <= xx_p1_r;
      yy_p2_r <= yy_p1_r;
      xy_p2_r <= xy_p1_r;
      x_p2_r  <= x_p1_r;
      y_p2_r  <= y_p1_r;
    end
  end

  // --------------------------------------------------------------------------
  // P3: r^4, k1 term, tangential terms
  // --------------------------------------------------------------------------
  logic signed [2*R2W-1:0]  pr4;
  logic signed [CW+R2W-1:0] pk1;
  logic signed [TAW-1:0]    tax, tay;
  logic signed [CW+TAW-1:0] ptx_b, pty_a;
  logic signed [CW+PW:0]    ptx_a, pty_b;
  logic signed [R4W-1:0]    r4_p3_r;
  logic signed [R2W-1:0]    r2_p3_r;
  logic signed [MW-1:0]     t1_p3_r;
  logic signed [TW-1:0]     tx_p3_r, ty_p3_r;
  logic signed [XW-1:0]     x_p3_r, y_p3_r;

  always_comb begin
    pr4   = (2*R2W)'(r2_p2_r) * (2*R2W)'(r2_p2_r);
    pk1   = (CW+R2W)'($signed(k1_r)) * (CW+R2W)'(r2_p2_r);
    tax   = TAW'(r2_p2_r) + (TAW'(xx_p2_r) <<< 1);
    tay   = TAW'(r2_p2_r) + (TAW'(yy_p2_r) <<< 1);
    ptx_b = (CW+TAW)'($signed(p2_r)) * (CW+TAW)'(tax);
    pty_a = (CW+TAW)'($signed(p1_r)) * (CW+TAW)'(tay);
    // doubled cross terms: double before the floor shift
    ptx_a = ((CW+PW+1)'($signed(p1_r)) * (CW+PW+1)'(xy_p2_r)) <<< 1;
    pty_b = ((CW+PW+1)'($signed(p2_r)) * (CW+PW+1)'(xy_p2_r)) <<< 1;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r4_p3_r <= R4W'(pr4 >>> F);
      r2_p3_r <= r2_p2_r;
      t1_p3_r <= MW'(pk1 >>> COEF_FRAC);
      tx_p3_r <= TW'(ptx_a >>> COEF_FRAC) + TW'(ptx_b >>> COEF_FRAC);
      ty_p3_r <= TW'(pty_a >>> COEF_FRAC) + TW'(pty_b >>> COEF_FRAC);
      x_p3_r  <= x_p2_r;
      y_p3_r  <= y_p2_r;
    end
  end

  // --------------------------------------------------------------------------
  // P4: r^6 and k2 term
  // --------------------------------------------------------------------------
  logic signed [R4W+R2W-1:0] pr6;
  logic signed [CW+R4W-1:0]  pk2;
  logic signed [R6W-1:0]     r6_p4_r;
  logic signed [MW-1:0]      t12_p4_r;
  logic signed [TW-1:0]      tx_p4_r, ty_p4_r;
  logic signed [XW-1:0]      x_p4_r, y_p4_r;

  assign pr6 = (R4W+R2W)'(r4_p3_r) * (R4W+R2W)'(r2_p3_r);
  assign pk2 = (CW+R4W)'($signed(k2_r)) * (CW+R4W)'(r4_p3_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      r6_p4_r  <= R6W'(pr6 >>> F);
      t12_p4_r <= t1_p3_r + MW'(pk2 >>> COEF_FRAC);
      tx_p4_r  <= tx_p3_r;
      ty_p4_r  <= ty_p3_r;
      x_p4_r   <= x_p3_r;
      y_p4_r   <= y_p3_r;
    end
  end

  // --------------------------------------------------------------------------
  // P5: radial factor m
  // --------------------------------------------------------------------------
  logic signed [CW+R6W-1:0] pk3;
  logic signed [MW-1:0]     m_p5_r;
  logic signed [TW-1:0]     tx_p5_r, ty_p5_r;
  logic signed [XW-1:0]     x_p5_r, y_p5_r;

  assign pk3 = (CW+R6W)'($signed(k3_r)) * (CW+R6W)'(r6_p4_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      m_p5_r  <= (MW'(1) <<< F) + t12_p4_r + MW'(pk3 >>> COEF_FRAC);
      tx_p5_r <= tx_p4_r;
      ty_p5_r <= ty_p4_r;
      x_p5_r  <= x_p4_r;
      y_p5_r  <= y_p4_r;
    end
  end

  // --------------------------------------------------------------------------
  // P6: distorted normalised coordinates
  // --------------------------------------------------------------------------
  logic signed [XW+MW-1:0] pxm, pym;
  logic signed [DXW-1:0]   xd_p6_r, yd_p6_r;

  assign pxm = (XW+MW)'(x_p5_r) * (XW+MW)'(m_p5_r);
  assign pym = (XW+MW)'(y_p5_r) * (XW+MW)'(m_p5_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      xd_p6_r <= DXW'(pxm >>> F) + DXW'(tx_p5_r);
      yd_p6_r <= DXW'(pym >>> F) + DXW'(ty_p5_r);
    end
  end

  // --------------------------------------------------------------------------
  // P7: back to pixels, scaled by 2^F
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] sx_p7_r, sy_p7_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sx_p7_r <= SW'($signed({1'b0, dim_l[0]})) * SW'(xd_p6_r) +
                 (SW'($signed({1'b0, dim_l[0] >> 1})) <<< F);
      sy_p7_r <= SW'($signed({1'b0, dim_l[1]})) * SW'(yd_p6_r) +
                 (SW'($signed({1'b0, dim_l[1] >> 1})) <<< F);
    end
  end

  // --------------------------------------------------------------------------
  // Output: truncate toward zero, saturate, border bypass
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] sx_adj, sy_adj;
  logic signed [VW-1:0] vx, vy;
  logic                 satx, saty;
  logic signed [15:0]   ox, oy;
  out_beat_t            out_nxt, out_data_r;

  always_comb begin
    sx_adj = sx_p7_r + (sx_p7_r[SW-1] ? ((SW'(1) <<< F) - SW'(1)) : SW'(0));
    sy_adj = sy_p7_r + (sy_p7_r[SW-1] ? ((SW'(1) <<< F) - SW'(1)) : SW'(0));
    vx     = VW'(sx_adj >>> F);
    vy     = VW'(sy_adj >>> F);
    satx   = (vx > VW'(32767)) || (vx < -VW'(32768));
    saty   = (vy > VW'(32767)) || (vy < -VW'(32768));
    if (vx > VW'(32767))       ox = 16'sh7FFF;
    else if (vx < -VW'(32768)) ox = -16'sh8000;
    else                       ox = 16'(vx);
    if (vy > VW'(32767))       oy = 16'sh7FFF;
    else if (vy < -VW'(32768)) oy = -16'sh8000;
    else                       oy = 16'(vy);
    if (meta_r[IP7].is_border) begin
      out_nxt.x_out     = $signed({4'd0, meta_r[IP7].x_in});
      out_nxt.y_out     = $signed({4'd0, meta_r[IP7].y_in});
      out_nxt.saturated = 1'b0;
    end else begin
      out_nxt.x_out     = ox;
      out_nxt.y_out     = oy;
      out_nxt.saturated = satx || saty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) out_data_r <= out_nxt;
  end

  assign out_valid = vld_r[IO];
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_border_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && vld_r[IP7] && meta_r[IP7].is_border) |=>
      (out_valid && !out_data.saturated))
    else $error("border beat left the pipe marked saturated");

  a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.saturated) |->
      (out_data.x_out == 16'sh7FFF || out_data.x_out == -16'sh8000 ||
       out_data.y_out == 16'sh7FFF || out_data.y_out == -16'sh8000))
    else $error("saturated flag without a clamped coordinate");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[IN_S] |-> (xn_r <= LIM && xn_r >= -LIM && yn_r <= LIM && yn_r >= -LIM))
    else $error("normalised coordinate beyond the limit");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[F+1] && !dovf_r[F][0]) |-> (drem_r[F][0] < RW'(dim_l[0])))
    else $error("divider remainder not below the frame width");

endmodule

`default_nettype wire
